// File: rtl/core/bamb_pkg.sv
// ----------------------------------------------------------------------------
// bamb_pkg
// Types, constants and register codes shared by the alpha mask blend block.
// ----------------------------------------------------------------------------
package bamb_pkg;

	localparam int MASK_SIDE  = 64;
	localparam int MASK_LOG   = $clog2(MASK_SIDE);
	localparam int MASK_DEPTH = MASK_SIDE * MASK_SIDE;
	// Mask position with 8 fraction bits, 0 .. (MASK_SIDE-1)*256.
	localparam int POS_W      = MASK_LOG + 8;
	localparam int POS_TOP    = (MASK_SIDE - 1) * 256;
	// The mask is split into four banks by row and column parity.
	localparam int BANK_AW    = 2 * (MASK_LOG - 1);

	localparam int CFG_W      = 24;

	typedef enum logic [2:0] {
		REG_SCREEN_WIDTH,
		REG_SCREEN_HEIGHT,
		REG_ORIGIN_X,
		REG_ORIGIN_Y,
		REG_MASK_STEP,
		REG_TINT_RED,
		REG_TINT_GREEN,
		REG_TINT_BLUE
	} cfg_reg_t;

	localparam logic KIND_LOAD  = 1'b0;
	localparam logic KIND_PIXEL = 1'b1;

	typedef struct packed {
		logic        kind;
		logic [11:0] texel_index;
		logic [7:0]  texel_alpha;
		logic [9:0]  pixel_x;
		logic [9:0]  pixel_y;
		logic [31:0] old_pixel;
	} in_item_t;

	typedef struct packed {
		logic [31:0] new_pixel;
		logic        drawn;
	} out_item_t;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
	} tint_t;

endpackage

// File: rtl/core/bamb_map_axis.sv
// ----------------------------------------------------------------------------
// bamb_map_axis
// Three-stage mapping of one screen coordinate into clamped mask space.
// ----------------------------------------------------------------------------
module bamb_map_axis (
	input  logic                       clk,
	input  logic                       en,
	input  logic [9:0]                 pos,
	input  logic signed [18:0]         origin,
	input  logic [23:0]                step,
	output logic [bamb_pkg::POS_W-1:0] mpos
);

	logic signed [20:0] d_s1;
	logic signed [45:0] p_s2;
	logic [bamb_pkg::POS_W-1:0] s_s3;

	logic signed [20:0] d_next;
	logic [29:0] q;
	logic [29:0] s_raw;

	// Pixel centre relative to the mask edge, 8 fraction bits.
	assign d_next = $signed({3'b000, pos, 8'h80}) - 21'(origin);

	assign q     = p_s2[45:16];
	assign s_raw = q - 30'd128;

	always_ff @(posedge clk) begin
		if (en) begin
			d_s1 <= d_next;
			p_s2 <= d_s1 * $signed({1'b0, step});
			if (p_s2[45] || q < 30'd128) begin
				s_s3 <= '0;
			end else if (s_raw > 30'(bamb_pkg::POS_TOP)) begin
				s_s3 <= bamb_pkg::POS_W'(bamb_pkg::POS_TOP);
			end else begin
				s_s3 <= s_raw[bamb_pkg::POS_W-1:0];
			end
		end
	end

	assign mpos = s_s3;

endmodule

// File: rtl/core/bamb_mask_mem.sv
// ----------------------------------------------------------------------------
// bamb_mask_mem
// Mask store in four parity banks, so the four bilinear neighbors are read
// in the same cycle with one read per bank.
// ----------------------------------------------------------------------------
module bamb_mask_mem (
	input  logic                       clk,
	input  logic                       en,
	input  logic                       we,
	input  logic [11:0]                widx,
	input  logic [7:0]                 wdata,
	input  logic [bamb_pkg::POS_W-1:0] sx,
	input  logic [bamb_pkg::POS_W-1:0] sy,
	output logic [7:0]                 t00,
	output logic [7:0]                 t01,
	output logic [7:0]                 t10,
	output logic [7:0]                 t11
);

	localparam int L = bamb_pkg::MASK_LOG;

	logic [7:0] mem [4][2**bamb_pkg::BANK_AW];
	logic [7:0] rd_s4 [4];
	logic ix0_s4, nx0_s4, iy0_s4, ny0_s4;

	logic [2*L-1:0] widx_ext;
	logic [L-1:0] wrow, wcol;
	logic [1:0] wbank;
	logic [bamb_pkg::BANK_AW-1:0] waddr;
	logic wok;

	logic [L-1:0] ix, iy, nx, ny;
	logic [L-1:0] rrow [4];
	logic [L-1:0] rcol [4];
	logic [bamb_pkg::BANK_AW-1:0] raddr [4];

	assign widx_ext = (2*L)'(widx);
	assign wrow     = widx_ext[2*L-1:L];
	assign wcol     = widx_ext[L-1:0];
	assign wbank    = {wrow[0], wcol[0]};
	assign waddr    = {wrow[L-1:1], wcol[L-1:1]};
	assign wok      = int'(widx) < bamb_pkg::MASK_DEPTH;

	assign ix = sx[bamb_pkg::POS_W-1:8];
	assign iy = sy[bamb_pkg::POS_W-1:8];
	assign nx = (ix == L'(bamb_pkg::MASK_SIDE - 1)) ? ix : ix + L'(1);
	assign ny = (iy == L'(bamb_pkg::MASK_SIDE - 1)) ? iy : iy + L'(1);

	// Each bank serves whichever neighbor has its parity; at the last
	// column or row both neighbors fall in the same bank and entry.
	always_comb begin
		for (int b = 0; b < 4; b++) begin
			rcol[b]  = (ix[0] == b[0]) ? ix : nx;
			rrow[b]  = (iy[0] == b[1]) ? iy : ny;
			raddr[b] = {rrow[b][L-1:1], rcol[b][L-1:1]};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int b = 0; b < 4; b++) begin
				if (we && wok && wbank == 2'(b)) begin
					mem[b][waddr] <= wdata;
				end
				rd_s4[b] <= mem[b][raddr[b]];
			end
			ix0_s4 <= ix[0];
			nx0_s4 <= nx[0];
			iy0_s4 <= iy[0];
			ny0_s4 <= ny[0];
		end
	end

	assign t00 = rd_s4[{iy0_s4, ix0_s4}];
	assign t01 = rd_s4[{iy0_s4, nx0_s4}];
	assign t10 = rd_s4[{ny0_s4, ix0_s4}];
	assign t11 = rd_s4[{ny0_s4, nx0_s4}];

endmodule

// File: rtl/core/bamb_filter.sv
// ----------------------------------------------------------------------------
// bamb_filter
// Two-stage bilinear mix of four texels into one rounded alpha.
// ----------------------------------------------------------------------------
module bamb_filter (
	input  logic       clk,
	input  logic       en,
	input  logic [7:0] t00,
	input  logic [7:0] t01,
	input  logic [7:0] t10,
	input  logic [7:0] t11,
	input  logic [7:0] fx,
	input  logic [7:0] fy,
	output logic [7:0] alpha
);

	logic [15:0] a0_s5, a1_s5;
	logic [7:0]  fy_s5;
	logic [7:0]  alpha_s6;

	logic [8:0]  wx0, wy0;
	logic [23:0] sum;

	assign wx0 = 9'd256 - {1'b0, fx};
	assign wy0 = 9'd256 - {1'b0, fy_s5};
	assign sum = 24'(a0_s5 * wy0) + 24'(a1_s5 * {1'b0, fy_s5}) + 24'd32768;

	always_ff @(posedge clk) begin
		if (en) begin
			a0_s5    <= 16'(t00 * wx0) + 16'(t01 * fx);
			a1_s5    <= 16'(t10 * wx0) + 16'(t11 * fx);
			fy_s5    <= fy;
			alpha_s6 <= sum[23:16];
		end
	end

	assign alpha = alpha_s6;

endmodule

// File: rtl/core/bamb_blend.sv
// ----------------------------------------------------------------------------
// bamb_blend
// Per-channel tint blend with the divide by 255 done as add and shift.
// ----------------------------------------------------------------------------
module bamb_blend (
	input  logic            clk,
	input  logic            en,
	input  bamb_pkg::tint_t tint,
	input  logic [23:0]     old_rgb,
	input  logic [7:0]      alpha,
	output logic [23:0]     new_rgb
);

	logic [15:0] n_s7 [3];

	logic [7:0] tc [3];
	logic [7:0] inv;
	logic [15:0] qsum [3];

	assign tc[0] = tint.red;
	assign tc[1] = tint.green;
	assign tc[2] = tint.blue;
	assign inv   = 8'd255 - alpha;

	// For n below 65535, (n + (n >> 8) + 1) >> 8 equals n / 255. The quotient
	// is left unregistered here and lands in the output register of the top.
	always_comb begin
		for (int c = 0; c < 3; c++) begin
			qsum[c] = n_s7[c] + 16'(n_s7[c][15:8]) + 16'd1;
			new_rgb[8*c +: 8] = qsum[c][15:8];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int c = 0; c < 3; c++) begin
				n_s7[c] <= 16'(tc[c] * alpha) + 16'(old_rgb[8*c +: 8] * inv) + 16'd127;
			end
		end
	end

endmodule

// File: rtl/core/bilinear_alpha_mask_blend.sv
// ----------------------------------------------------------------------------
// bilinear_alpha_mask_blend
// Tinted blend of a scaled, bilinear filtered alpha mask over pixels.
// ----------------------------------------------------------------------------
// An eight-stage pipeline that accepts one transaction per cycle, load or
// pixel, unless the output stalls. A pixel's result passes the stage
// registers in order and is taken from the output register. The stages are
// mapping add, mapping multiply, clamp, banked mask read, horizontal mix,
// vertical mix, channel blend and divide. When the output is stalled the
// whole pipeline holds, so in_stall follows out_valid and out_stall. Loads
// write the mask in the fourth stage, in order with pixels, so a pixel sees
// every load accepted before it. The mask is not cleared at reset; every
// entry must be loaded before a pixel reads it.
// ----------------------------------------------------------------------------
module bilinear_alpha_mask_blend (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  bamb_pkg::in_item_t         in_data,
	output logic                       out_valid,
	input  logic                       out_stall,
	output bamb_pkg::out_item_t        out_data,
	input  logic                       cfg_write,
	input  logic [2:0]                 cfg_index,
	input  logic [bamb_pkg::CFG_W-1:0] cfg_data
);

	logic [10:0]        screen_width_q, screen_height_q;
	logic signed [18:0] origin_x_q, origin_y_q;
	logic [23:0]        mask_step_q;
	bamb_pkg::tint_t    tint_q;

	logic adv;

	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8;
	bamb_pkg::in_item_t item_s1, item_s2, item_s3;
	logic kind_s4, kind_s5, kind_s6, kind_s7;
	logic on_s1, on_s2, on_s3, on_s4, on_s5, on_s6, on_s7;
	logic [31:0] old_s4, old_s5, old_s6, old_s7;
	logic [7:0] fx_s4, fy_s4;
	bamb_pkg::out_item_t out_s8;

	logic on_next;
	logic [bamb_pkg::POS_W-1:0] sx, sy;
	logic [7:0] t00, t01, t10, t11, alpha;
	logic [23:0] new_rgb;

	assign adv      = !v_s8 || !out_stall;
	assign in_stall = !adv;
	assign on_next  = ({1'b0, in_data.pixel_x} < screen_width_q) &&
	                  ({1'b0, in_data.pixel_y} < screen_height_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			screen_width_q  <= 11'd320;
			screen_height_q <= 11'd240;
			origin_x_q      <= 19'sd38124;
			origin_y_q      <= 19'sd28160;
			mask_step_q     <= 24'd291271;
			tint_q          <= '{red: 8'd214, green: 8'd177, blue: 8'd87};
		end else if (cfg_write) begin
			case (bamb_pkg::cfg_reg_t'(cfg_index))
				bamb_pkg::REG_SCREEN_WIDTH:  screen_width_q  <= cfg_data[10:0];
				bamb_pkg::REG_SCREEN_HEIGHT: screen_height_q <= cfg_data[10:0];
				bamb_pkg::REG_ORIGIN_X:      origin_x_q      <= cfg_data[18:0];
				bamb_pkg::REG_ORIGIN_Y:      origin_y_q      <= cfg_data[18:0];
				bamb_pkg::REG_MASK_STEP:     mask_step_q     <= cfg_data[23:0];
				bamb_pkg::REG_TINT_RED:      tint_q.red      <= cfg_data[7:0];
				bamb_pkg::REG_TINT_GREEN:    tint_q.green    <= cfg_data[7:0];
				bamb_pkg::REG_TINT_BLUE:     tint_q.blue     <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0; v_s2 <= 1'b0; v_s3 <= 1'b0; v_s4 <= 1'b0;
			v_s5 <= 1'b0; v_s6 <= 1'b0; v_s7 <= 1'b0; v_s8 <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
			v_s7 <= v_s6;
			// Loads end here; only pixels reach the output register.
			v_s8 <= v_s7 && kind_s7 == bamb_pkg::KIND_PIXEL;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			item_s1 <= in_data;  on_s1 <= on_next;
			item_s2 <= item_s1;  on_s2 <= on_s1;
			item_s3 <= item_s2;  on_s3 <= on_s2;
			kind_s4 <= item_s3.kind; old_s4 <= item_s3.old_pixel; on_s4 <= on_s3;
			fx_s4   <= sx[7:0];
			fy_s4   <= sy[7:0];
			kind_s5 <= kind_s4; old_s5 <= old_s4; on_s5 <= on_s4;
			kind_s6 <= kind_s5; old_s6 <= old_s5; on_s6 <= on_s5;
			kind_s7 <= kind_s6; old_s7 <= old_s6; on_s7 <= on_s6;
			if (on_s7) begin
				out_s8.new_pixel <= {8'hFF, new_rgb};
				out_s8.drawn     <= 1'b1;
			end else begin
				out_s8.new_pixel <= old_s7;
				out_s8.drawn     <= 1'b0;
			end
		end
	end

	bamb_map_axis u_map_x (
		.clk    (clk),
		.en     (adv),
		.pos    (in_data.pixel_x),
		.origin (origin_x_q),
		.step   (mask_step_q),
		.mpos   (sx)
	);

	bamb_map_axis u_map_y (
		.clk    (clk),
		.en     (adv),
		.pos    (in_data.pixel_y),
		.origin (origin_y_q),
		.step   (mask_step_q),
		.mpos   (sy)
	);

	bamb_mask_mem u_mem (
		.clk   (clk),
		.en    (adv),
		.we    (v_s3 && item_s3.kind == bamb_pkg::KIND_LOAD),
		.widx  (item_s3.texel_index),
		.wdata (item_s3.texel_alpha),
		.sx    (sx),
		.sy    (sy),
		.t00   (t00),
		.t01   (t01),
		.t10   (t10),
		.t11   (t11)
	);

	bamb_filter u_filter (
		.clk   (clk),
		.en    (adv),
		.t00   (t00),
		.t01   (t01),
		.t10   (t10),
		.t11   (t11),
		.fx    (fx_s4),
		.fy    (fy_s4),
		.alpha (alpha)
	);

	bamb_blend u_blend (
		.clk     (clk),
		.en      (adv),
		.tint    (tint_q),
		.old_rgb (old_s6[23:0]),
		.alpha   (alpha),
		.new_rgb (new_rgb)
	);

	assign out_valid = v_s8;
	assign out_data  = out_s8;

	a_drawn_alpha: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.drawn |-> out_data.new_pixel[31:24] == 8'hFF)
		else $error("blended pixel without opaque alpha byte");

	a_stall_source: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("pipeline held without a stalled result");

	a_pixel_reaches_out: assert property (@(posedge clk) disable iff (!arst_n)
		adv && v_s7 && kind_s7 == bamb_pkg::KIND_PIXEL |=> out_valid)
		else $error("pixel lost at the output register");

	a_load_no_result: assert property (@(posedge clk) disable iff (!arst_n)
		adv && v_s7 && kind_s7 == bamb_pkg::KIND_LOAD && !v_s6 |=> !out_valid)
		else $error("load produced a result");

endmodule

// File: sim/bilinear_alpha_mask_blend_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bilinear_alpha_mask_blend_test
// Self-checking bench for the tinted, bilinear filtered alpha mask blend.
// Mask loads and pixel transactions are driven with random gaps on input and
// output. Every pixel result is predicted in the bench and compared in order.
// A table of directed rows comes first, then random traffic under several
// register settings, including an extreme value of each register.
// ----------------------------------------------------------------------------
module bilinear_alpha_mask_blend_test;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	bamb_pkg::in_item_t in_data = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	bamb_pkg::out_item_t out_data;
	logic cfg_write = 1'b0;
	logic [2:0] cfg_index = '0;
	logic [bamb_pkg::CFG_W-1:0] cfg_data = '0;

	bilinear_alpha_mask_blend DUT (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
		.cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always #5 clk = ~clk;

	// Predictor state.
	logic [10:0] width_q, height_q;
	logic signed [18:0] org_x, org_y;
	logic [23:0] step_q;
	bamb_pkg::tint_t tint_q;
	logic [7:0] mask_q [bamb_pkg::MASK_DEPTH];

	bamb_pkg::out_item_t pixel_queue[$];
	int errors = 0;
	int pixels_checked = 0;
	int loads_sent = 0;
	bit idle_out = 1'b0;
	int out_gap_max = 30;
	int stall_left = 0;

	function automatic int axis_position(logic [9:0] pos, logic signed [18:0] org);
		longint d, p, s;
		d = longint'(pos) * 256 + 128 - longint'(org);
		p = d * longint'(step_q);
		if (p < 0)
			return 0;
		s = (p >> 16) - 128;
		if (s < 0) s = 0;
		if (s > bamb_pkg::POS_TOP) s = bamb_pkg::POS_TOP;
		return int'(s);
	endfunction

	function automatic logic [7:0] mix(logic [7:0] t, logic [7:0] o, int a);
		return 8'((int'(t) * a + int'(o) * (255 - a) + 127) / 255);
	endfunction

	function automatic bamb_pkg::out_item_t blended_pixel(bamb_pkg::in_item_t it);
		bamb_pkg::out_item_t r;
		int sx, sy, ix, iy, nx, ny, fx, fy, a0, a1, alpha;
		if (it.pixel_x >= width_q || it.pixel_y >= height_q) begin
			r.new_pixel = it.old_pixel;
			r.drawn = 1'b0;
			return r;
		end
		sx = axis_position(it.pixel_x, org_x);
		sy = axis_position(it.pixel_y, org_y);
		ix = sx >> 8; fx = sx & 255;
		iy = sy >> 8; fy = sy & 255;
		nx = ix < bamb_pkg::MASK_SIDE - 1 ? ix + 1 : ix;
		ny = iy < bamb_pkg::MASK_SIDE - 1 ? iy + 1 : iy;
		a0 = mask_q[iy * bamb_pkg::MASK_SIDE + ix] * (256 - fx) +
			mask_q[iy * bamb_pkg::MASK_SIDE + nx] * fx;
		a1 = mask_q[ny * bamb_pkg::MASK_SIDE + ix] * (256 - fx) +
			mask_q[ny * bamb_pkg::MASK_SIDE + nx] * fx;
		alpha = (a0 * (256 - fy) + a1 * fy + 32768) >> 16;
		r.new_pixel = {8'hFF, mix(tint_q.blue, it.old_pixel[23:16], alpha),
			mix(tint_q.green, it.old_pixel[15:8], alpha),
			mix(tint_q.red, it.old_pixel[7:0], alpha)};
		r.drawn = 1'b1;
		return r;
	endfunction

	// The enable drops after each write, before the next one.
	task automatic write_reg(bamb_pkg::cfg_reg_t idx, logic [bamb_pkg::CFG_W-1:0] val);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_write <= 1'b0;
		@(posedge clk);
		case (idx)
			bamb_pkg::REG_SCREEN_WIDTH: width_q = val[10:0];
			bamb_pkg::REG_SCREEN_HEIGHT: height_q = val[10:0];
			bamb_pkg::REG_ORIGIN_X: org_x = val[18:0];
			bamb_pkg::REG_ORIGIN_Y: org_y = val[18:0];
			bamb_pkg::REG_MASK_STEP: step_q = val;
			bamb_pkg::REG_TINT_RED: tint_q.red = val[7:0];
			bamb_pkg::REG_TINT_GREEN: tint_q.green = val[7:0];
			bamb_pkg::REG_TINT_BLUE: tint_q.blue = val[7:0];
			default: ;
		endcase
	endtask

	// Sends one transaction; known, when set, overrides the predicted result.
	task automatic send(bamb_pkg::in_item_t it, bit known = 1'b0,
		bamb_pkg::out_item_t want = '0);
		in_valid <= 1'b1;
		in_data <= it;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		if (it.kind == bamb_pkg::KIND_LOAD) begin
			mask_q[it.texel_index] = it.texel_alpha;
			loads_sent++;
		end else
			pixel_queue.push_back(known ? want : blended_pixel(it));
	endtask

	task automatic gap;
		int n;
		n = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30) : $urandom_range(0, 2);
		if ($urandom_range(0, 3) == 0)
			n = 0;
		if (n > 0) begin
			in_valid <= 1'b0;
			repeat (n) @(posedge clk);
		end
	endtask

	task automatic drain;
		in_valid <= 1'b0;
		while (pixel_queue.size() != 0)
			@(posedge clk);
		repeat (12) @(posedge clk);
	endtask

	function automatic bamb_pkg::in_item_t load_item(int idx, int a);
		bamb_pkg::in_item_t it;
		it = '0;
		it.kind = bamb_pkg::KIND_LOAD;
		it.texel_index = 12'(idx);
		it.texel_alpha = 8'(a);
		it.pixel_x = 10'($urandom);
		it.pixel_y = 10'($urandom);
		it.old_pixel = $urandom;
		return it;
	endfunction

	function automatic bamb_pkg::in_item_t pixel_item(int x, int y, logic [31:0] old);
		bamb_pkg::in_item_t it;
		it = '0;
		it.kind = bamb_pkg::KIND_PIXEL;
		it.texel_index = 12'($urandom);
		it.texel_alpha = 8'($urandom);
		it.pixel_x = 10'(x);
		it.pixel_y = 10'(y);
		it.old_pixel = old;
		return it;
	endfunction

	// Output side: random stalls, compare against the oldest expectation.
	always @(posedge clk) begin
		if (out_valid && !out_stall) begin
			if (pixel_queue.size() == 0) begin
				$display("%0t: unexpected result %h/%b", $time,
					out_data.new_pixel, out_data.drawn);
				errors++;
			end else begin
				bamb_pkg::out_item_t w;
				w = pixel_queue.pop_front();
				pixels_checked++;
				if (w.new_pixel !== out_data.new_pixel) begin
					$display("%0t: new_pixel expected %h actual %h", $time,
						w.new_pixel, out_data.new_pixel);
					errors++;
				end
				if (w.drawn !== out_data.drawn) begin
					$display("%0t: drawn expected %b actual %b", $time,
						w.drawn, out_data.drawn);
					errors++;
				end
			end
		end
		if (idle_out) begin
			out_stall <= 1'b0;
			stall_left = 0;
		end else if (stall_left > 0) begin
			out_stall <= 1'b1;
			stall_left--;
		end else if ($urandom_range(0, 3) == 0) begin
			out_stall <= 1'b1;
			// Most stalls last a cycle; now and then one runs long.
			stall_left = ($urandom_range(0, 19) == 0) ? $urandom_range(5, out_gap_max) : 0;
		end else
			out_stall <= 1'b0;
	end

	typedef struct {
		bamb_pkg::in_item_t item;
		bit known;
		bamb_pkg::out_item_t want;
	} table_row_t;

	initial begin
		table_row_t rows[$];
		int phase, n;
		bamb_pkg::in_item_t it;
		width_q = 320; height_q = 240; org_x = 38124; org_y = 28160;
		step_q = 291271;
		tint_q.red = 214; tint_q.green = 177; tint_q.blue = 87;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Fill the whole mask so that no read touches an unwritten entry.
		for (int i = 0; i < bamb_pkg::MASK_DEPTH; i++) begin
			send(load_item(i, (i % 7 == 0) ? 255 : (i % 11 == 0) ? 0 : $urandom_range(0, 255)));
			if (i % 512 == 0)
				gap();
		end

		// Directed rows: off-screen pass-through, screen corners, extremes.
		rows.push_back('{pixel_item(320, 0, 32'h12345678), 1, '{32'h12345678, 1'b0}});
		rows.push_back('{pixel_item(0, 240, 32'hFFFFFFFF), 1, '{32'hFFFFFFFF, 1'b0}});
		rows.push_back('{pixel_item(1023, 1023, 32'h0), 1, '{32'h0, 1'b0}});
		rows.push_back('{pixel_item(0, 0, 32'h0), 0, '0});
		rows.push_back('{pixel_item(319, 239, 32'hFFFFFFFF), 0, '0});
		rows.push_back('{pixel_item(160, 120, 32'hA5A5A5A5), 0, '0});
		rows.push_back('{load_item(4095, 255), 0, '0});
		rows.push_back('{load_item(0, 0), 0, '0});
		rows.push_back('{pixel_item(319, 239, 32'h00FF00FF), 0, '0});
		rows.push_back('{pixel_item(0, 0, 32'hFF00FF00), 0, '0});
		foreach (rows[i])
			send(rows[i].item, rows[i].known, rows[i].want);
		drain();

		for (phase = 0; phase < 6; phase++) begin
			case (phase)
				0: begin
					write_reg(bamb_pkg::REG_SCREEN_WIDTH, 1024);
					write_reg(bamb_pkg::REG_SCREEN_HEIGHT, 1024);
					write_reg(bamb_pkg::REG_ORIGIN_X, 24'(-19'sd262144));
					write_reg(bamb_pkg::REG_ORIGIN_Y, 24'(19'sd262143));
					write_reg(bamb_pkg::REG_MASK_STEP, 16777215);
					write_reg(bamb_pkg::REG_TINT_RED, 0);
					write_reg(bamb_pkg::REG_TINT_GREEN, 255);
					write_reg(bamb_pkg::REG_TINT_BLUE, 0);
				end
				1: begin
					write_reg(bamb_pkg::REG_SCREEN_WIDTH, 1);
					write_reg(bamb_pkg::REG_SCREEN_HEIGHT, 1);
					write_reg(bamb_pkg::REG_MASK_STEP, 0);
					write_reg(bamb_pkg::REG_TINT_RED, 255);
					write_reg(bamb_pkg::REG_TINT_BLUE, 255);
				end
				2: begin
					write_reg(bamb_pkg::REG_SCREEN_WIDTH, 300);
					write_reg(bamb_pkg::REG_SCREEN_HEIGHT, 200);
					write_reg(bamb_pkg::REG_ORIGIN_X, 24'(-19'sd2560));
					write_reg(bamb_pkg::REG_ORIGIN_Y, 1000);
					write_reg(bamb_pkg::REG_MASK_STEP, 1);
				end
				default: begin
					write_reg(bamb_pkg::REG_SCREEN_WIDTH, $urandom_range(1, 1024));
					write_reg(bamb_pkg::REG_SCREEN_HEIGHT, $urandom_range(1, 1024));
					write_reg(bamb_pkg::REG_ORIGIN_X,
						24'(19'($urandom_range(0, 80000) - 20000)));
					write_reg(bamb_pkg::REG_ORIGIN_Y,
						24'(19'($urandom_range(0, 60000) - 15000)));
					write_reg(bamb_pkg::REG_MASK_STEP, $urandom_range(20000, 400000));
					write_reg(bamb_pkg::REG_TINT_RED, $urandom_range(0, 255));
					write_reg(bamb_pkg::REG_TINT_GREEN, $urandom_range(0, 255));
					write_reg(bamb_pkg::REG_TINT_BLUE, $urandom_range(0, 255));
				end
			endcase
			n = 150;
			for (int k = 0; k < n; k++) begin
				if ($urandom_range(0, 9) == 0)
					it = load_item($urandom_range(0, 4095), $urandom_range(0, 255));
				else if ($urandom_range(0, 4) == 0)
					it = pixel_item($urandom_range(0, 1023), $urandom_range(0, 1023), $urandom);
				else
					it = pixel_item($urandom_range(0, width_q - 1) % 1024,
						$urandom_range(0, height_q - 1) % 1024, $urandom);
				send(it);
				// Hold off once per phase until everything in flight has returned.
				if (k == n / 2) begin
					in_valid <= 1'b0;
					while (pixel_queue.size() != 0)
						@(posedge clk);
				end else if (k > 20 && k < 60)
					gap();
				else if (k >= 60)
					gap();
			end
			drain();
		end

		idle_out = 1'b1;
		drain();
		$display("Covered %0d mask loads and %0d checked pixels over six register settings.",
			loads_sent, pixels_checked);
		if (errors == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

	initial begin
		#5ms;
		$display("Timeout with %0d results outstanding", pixel_queue.size());
		$display("CHECKS FAILED");
		$finish;
	end

endmodule

// File: bilinear_alpha_mask_blend.f
rtl/core/bamb_pkg.sv
rtl/core/bamb_map_axis.sv
rtl/core/bamb_mask_mem.sv
rtl/core/bamb_filter.sv
rtl/core/bamb_blend.sv
rtl/core/bilinear_alpha_mask_blend.sv
sim/bilinear_alpha_mask_blend_test.sv
